// ===== rtl/vmra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmra_pkg
// Shared types and constants for the message ring allocator.
// ----------------------------------------------------------------------------
package vmra_pkg;

    localparam int MAX_UNITS    = 1024;
    localparam int MAX_SLOTS    = 256;
    localparam int HEADER_BYTES = 4;

    localparam int UNIT_W  = $clog2(MAX_UNITS);      // unit index
    localparam int UCNT_W  = $clog2(MAX_UNITS + 1);  // unit count
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int DESC_W  = 2 * UNIT_W + 16;        // start, skip, length

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_SKIP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NO_SLOT = 3'd2,
        ST_NO_SPACE = 3'd3,
        ST_BAD_LEN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_UNIT_BYTES = 2'd0,
        REG_UNIT_COUNT = 2'd1,
        REG_SLOT_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] length;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [25:0] payload_offset;
        logic [15:0] msg_length;
        logic [6:0]  used_percent;
        logic [8:0]  msg_count;
    } rsp_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [26:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [26:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/vmra_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmra_req_if / vmra_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface vmra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] length;
    modport source (output valid, output cmd, output length, input ready);
    modport sink (input valid, input cmd, input length, output ready);
endinterface

interface vmra_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [25:0] payload_offset;
    logic [15:0] msg_length;
    logic [6:0]  used_percent;
    logic [8:0]  msg_count;
    modport source (output valid, output status, output payload_offset,
                    output msg_length, output used_percent, output msg_count,
                    input ready);
    modport sink (input valid, input status, input payload_offset,
                  input msg_length, input used_percent, input msg_count,
                  output ready);
endinterface

// ===== rtl/variable_message_ring_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_message_ring_allocator
// Ring allocator for variable-length messages with a descriptor table.
// ----------------------------------------------------------------------------
// Commands enter on req (cmd, length) and one result per command leaves on
// rsp. Configuration is written through cfg_we/cfg_index/cfg_data; a write
// to index 0..2 empties the queue. The sequencer runs up to two 27-step passes
// of the shared bit-serial divider (unit count for a command not rejected
// early, then fill percent), plus states for the descriptor RAM read, the
// space check and the payload offset multiply. A command rejected before the
// unit count pass goes straight to the fill percent pass. With rsp.ready high
// the next command is accepted once the sequencer is back in idle.
// req.ready is high only while the sequencer is idle. The result is held in
// an output register until taken; while rsp is stalled no new command is
// accepted. Reset restores unit_bytes 256, unit_count 1024, slot_count 256
// and an empty queue; the descriptor RAM needs no clearing.
// ----------------------------------------------------------------------------
module variable_message_ring_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    vmra_req_if.sink    req,
    vmra_rsp_if.source  rsp
);
    import vmra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NEED, S_NEED_W, S_CHECK, S_RD, S_RD_W, S_OFS, S_PCT,
        S_PCT_W, S_OUT
    } state_t;

    state_t              state_reg;
    logic [15:0]         ub_reg;
    logic [10:0]         uc_reg;
    logic [8:0]          sc_reg;
    logic [SLOT_W-1:0]   wslot_reg, rslot_reg;
    logic [SCNT_W-1:0]   held_reg;
    logic [UCNT_W-1:0]   free_reg;
    logic [UNIT_W-1:0]   nfu_reg;
    logic [1:0]          cmd_reg;
    logic [15:0]         len_reg;
    logic [UCNT_W:0]     need_reg;
    logic [2:0]          status_reg;
    logic [25:0]         ofs_reg;
    logic [15:0]         mlen_reg;
    logic                rsp_valid_reg;
    logic [6:0]          pct_reg;

    div_req_t            dreq;
    div_rsp_t            drsp;

    logic [15:0]         ub_eff;
    logic [UCNT_W-1:0]   tot_eff;
    logic [SCNT_W-1:0]   slots_eff;
    logic [UCNT_W-1:0]   used;
    logic [UCNT_W+1:0]   skip_w;
    logic [UCNT_W+1:0]   run_w;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_addr;
    logic [DESC_W-1:0]   ram_wdata, ram_rdata;
    logic [UNIT_W-1:0]   d_start, d_skip;
    logic [15:0]         d_len;
    logic [UCNT_W:0]     d_units;

    assign ub_eff    = (ub_reg == '0) ? 16'd1 : ub_reg;
    assign tot_eff   = (uc_reg == '0) ? UCNT_W'(1) :
                       (uc_reg > 11'(MAX_UNITS)) ? UCNT_W'(MAX_UNITS) : UCNT_W'(uc_reg);
    assign slots_eff = (sc_reg == '0) ? SCNT_W'(1) :
                       (sc_reg > 9'(MAX_SLOTS)) ? SCNT_W'(MAX_SLOTS) : SCNT_W'(sc_reg);
    assign used      = tot_eff - free_reg;
    assign skip_w    = ((UCNT_W+2)'(nfu_reg) + (UCNT_W+2)'(need_reg) >
                        (UCNT_W+2)'(tot_eff)) ?
                       (UCNT_W+2)'(tot_eff) - (UCNT_W+2)'(nfu_reg) : '0;
    assign run_w     = skip_w + (UCNT_W+2)'(need_reg);

    // descriptor: start, skip, length; unit count recomputed on read
    assign {d_start, d_skip, d_len} = ram_rdata;

    vmra_ram #(.WIDTH(DESC_W), .DEPTH(MAX_SLOTS)) u_desc (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vmra_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (dreq),
        .rsp (drsp)
    );

    assign ram_we    = (state_reg == S_CHECK) && (status_reg == ST_OK) &&
                       (run_w <= (UCNT_W+2)'(free_reg));
    assign ram_addr  = (state_reg == S_CHECK) ? wslot_reg : rslot_reg;
    assign ram_wdata = {nfu_reg, skip_w[UNIT_W-1:0], len_reg};

    always_comb
    begin
        dreq = '0;
        unique case (state_reg)
            S_NEED:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 27'(len_reg) + 27'(HEADER_BYTES) + 27'(ub_eff) - 27'd1;
                dreq.divisor  = ub_eff;
            end
            S_RD_W:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 27'(d_len) + 27'(HEADER_BYTES) + 27'(ub_eff) - 27'd1;
                dreq.divisor  = ub_eff;
            end
            S_PCT:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 27'(used) * 27'd100;
                dreq.divisor  = 16'(tot_eff);
            end
            default: ;
        endcase
    end
    assign d_units = (UCNT_W+1)'(drsp.quotient);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ub_reg        <= 16'd256;
            uc_reg        <= 11'd1024;
            sc_reg        <= 9'd256;
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            held_reg      <= '0;
            free_reg      <= UCNT_W'(MAX_UNITS);
            nfu_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                REG_UNIT_BYTES: ub_reg <= cfg_data;
                REG_UNIT_COUNT: uc_reg <= cfg_data[10:0];
                REG_SLOT_COUNT: sc_reg <= cfg_data[8:0];
                default: ;
            endcase
            if (cfg_index <= REG_SLOT_COUNT)
            begin
                wslot_reg <= '0;
                rslot_reg <= '0;
                held_reg  <= '0;
                nfu_reg   <= '0;
                if (cfg_index == REG_UNIT_COUNT)
                begin
                    free_reg <= (cfg_data[10:0] == '0) ? UCNT_W'(1) :
                                (cfg_data[10:0] > 11'(MAX_UNITS)) ? UCNT_W'(MAX_UNITS) :
                                UCNT_W'(cfg_data[10:0]);
                end
                else
                begin
                    free_reg <= tot_eff;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cmd_reg <= req.cmd;
                        len_reg <= req.length;
                        ofs_reg <= '0;
                        mlen_reg <= '0;
                        status_reg <= ST_OK;
                        if (req.cmd == CMD_WRITE)
                        begin
                            if (req.length > ub_eff)
                            begin
                                status_reg <= ST_BAD_LEN;
                                state_reg  <= S_PCT;
                            end
                            else if (held_reg >= slots_eff)
                            begin
                                status_reg <= ST_NO_SLOT;
                                state_reg  <= S_PCT;
                            end
                            else
                            begin
                                state_reg <= S_NEED;
                            end
                        end
                        else if (req.cmd == CMD_READ && req.length == '0)
                        begin
                            status_reg <= ST_BAD_LEN;
                            state_reg  <= S_PCT;
                        end
                        else if (held_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_PCT;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_NEED: state_reg <= S_NEED_W;
                S_NEED_W:
                begin
                    if (drsp.done)
                    begin
                        need_reg  <= d_units;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (run_w > (UCNT_W+2)'(free_reg))
                    begin
                        status_reg <= ST_NO_SPACE;
                    end
                    else
                    begin
                        ofs_reg  <= (skip_w == '0) ?
                                    26'(32'(nfu_reg) * 32'(ub_eff) + HEADER_BYTES) :
                                    26'(HEADER_BYTES);
                        mlen_reg <= len_reg;
                        nfu_reg  <= ((UCNT_W+2)'(nfu_reg) + run_w >= (UCNT_W+2)'(tot_eff)) ?
                                    UNIT_W'((UCNT_W+2)'(nfu_reg) + run_w - (UCNT_W+2)'(tot_eff)) :
                                    UNIT_W'((UCNT_W+2)'(nfu_reg) + run_w);
                        free_reg <= free_reg - UCNT_W'(run_w);
                        wslot_reg <= (SCNT_W'(wslot_reg) + 1'b1 >= slots_eff) ? '0 :
                                     wslot_reg + 1'b1;
                        held_reg <= held_reg + 1'b1;
                    end
                    state_reg <= S_PCT;
                end
                S_RD:   state_reg <= S_RD_W;
                S_RD_W: state_reg <= S_OFS;
                S_OFS:
                begin
                    if (drsp.done)
                    begin
                        ofs_reg  <= (d_skip == '0) ?
                                    26'(32'(d_start) * 32'(ub_eff) + HEADER_BYTES) :
                                    26'(HEADER_BYTES);
                        mlen_reg <= (cmd_reg == CMD_READ && len_reg < d_len) ?
                                    len_reg : d_len;
                        if (cmd_reg != CMD_PEEK)
                        begin
                            free_reg <= ((UCNT_W+2)'(free_reg) + (UCNT_W+2)'(d_units) +
                                         (UCNT_W+2)'(d_skip) > (UCNT_W+2)'(tot_eff)) ?
                                        tot_eff :
                                        UCNT_W'(free_reg + UCNT_W'(d_units) + UCNT_W'(d_skip));
                            rslot_reg <= (SCNT_W'(rslot_reg) + 1'b1 >= slots_eff) ? '0 :
                                         rslot_reg + 1'b1;
                            held_reg  <= held_reg - 1'b1;
                        end
                        state_reg <= S_PCT;
                    end
                end
                S_PCT: state_reg <= S_PCT_W;
                S_PCT_W:
                begin
                    if (drsp.done)
                    begin
                        pct_reg <= (used == '0) ? 7'd0 :
                                   (free_reg == '0) ? 7'd100 : 7'(drsp.quotient);
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready          = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.payload_offset = ofs_reg;
    assign rsp.msg_length     = mlen_reg;
    assign rsp.used_percent   = pct_reg;
    assign rsp.msg_count      = held_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= SCNT_W'(MAX_SLOTS))
        else $error("held count exceeds table");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= UCNT_W'(MAX_UNITS))
        else $error("free units exceed ring");
    a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> state_reg == S_OUT)
        else $error("result valid outside output state");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != ST_OK) |-> (ofs_reg == '0 && mlen_reg == '0))
        else $error("error result carries payload");
endmodule

// ===== rtl/vmra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmra_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module vmra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/vmra_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmra_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module vmra_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vmra_pkg::div_req_t req,
    output vmra_pkg::div_rsp_t rsp
);
    import vmra_pkg::*;

    localparam int QW = 27;

    logic [QW-1:0]   quo_reg, quo_next;
    logic [16:0]     rem_reg, rem_next;
    logic [15:0]     dvs_reg;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [16:0]     trial;
    logic [17:0]     diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[QW-1]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = 5'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ===== dv/variable_message_ring_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_message_ring_allocator_tb
// Self-checking bench for the message ring allocator. A directed table covers
// reset state, error codes, wrap skip, full table, full ring and register
// clamping. Random phases under several unit and slot settings follow. Each
// result is compared with the row's expectation where given, else an in-bench
// model of the allocator, with random gaps on commands and stalls on results.
// ----------------------------------------------------------------------------
module variable_message_ring_allocator_tb;
    import vmra_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;   // unmapped index, no effect
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 140;

    typedef struct {
        logic        is_cfg;
        logic [1:0]  idx;
        logic [15:0] data;
        cmd_t        cmd;
        logic [15:0] len;
        logic        has_exp;
        rsp_t        exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    vmra_req_if req ();
    vmra_rsp_if rsp ();

    variable_message_ring_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // allocator model state
    int unsigned reg_ub, reg_uc, reg_sc;
    int unsigned d_start [MAX_SLOTS];
    int unsigned d_units [MAX_SLOTS];
    int unsigned d_skip [MAX_SLOTS];
    int unsigned d_len [MAX_SLOTS];
    int unsigned wr_slot, rd_slot, held, free_u, next_u;

    rsp_t pending_rsp [$];
    row_t plan [$];
    int unsigned mismatches;
    int unsigned cycles;
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned eff_ub();
        return (reg_ub == 0) ? 1 : reg_ub;
    endfunction

    function automatic int unsigned eff_uc();
        if (reg_uc == 0) return 1;
        return (reg_uc > MAX_UNITS) ? MAX_UNITS : reg_uc;
    endfunction

    function automatic int unsigned eff_sc();
        if (reg_sc == 0) return 1;
        return (reg_sc > MAX_SLOTS) ? MAX_SLOTS : reg_sc;
    endfunction

    function automatic void empty_ring();
        wr_slot = 0;
        rd_slot = 0;
        held = 0;
        free_u = eff_uc();
        next_u = 0;
    endfunction

    function automatic logic [25:0] payload_at(int unsigned s);
        longint unsigned base;
        base = (d_skip[s] == 0) ? longint'(d_start[s]) * eff_ub() : 0;
        return 26'(base + HEADER_BYTES);
    endfunction

    function automatic rsp_t alloc_step(cmd_t c, logic [15:0] len);
        rsp_t r;
        int unsigned total, slots, ub, need, skp, s, used;
        total = eff_uc();
        slots = eff_sc();
        ub = eff_ub();
        r = '0;
        r.status = ST_OK;
        if (c == CMD_WRITE)
        begin
            if (len > ub)
                r.status = ST_BAD_LEN;
            else if (held >= slots)
                r.status = ST_NO_SLOT;
            else
            begin
                need = (len + HEADER_BYTES + ub - 1) / ub;
                skp = (next_u + need > total) ? total - next_u : 0;
                if (skp + need > free_u)
                    r.status = ST_NO_SPACE;
                else
                begin
                    s = wr_slot % slots;
                    d_start[s] = next_u;
                    d_units[s] = need;
                    d_skip[s] = skp;
                    d_len[s] = len;
                    r.payload_offset = payload_at(s);
                    r.msg_length = len;
                    next_u = (next_u + need + skp) % total;
                    free_u -= need + skp;
                    wr_slot = (s + 1) % slots;
                    held++;
                end
            end
        end
        else if (c == CMD_READ && len == 0)
            r.status = ST_BAD_LEN;
        else if (held == 0)
            r.status = ST_EMPTY;
        else
        begin
            s = rd_slot % slots;
            r.payload_offset = payload_at(s);
            r.msg_length = d_len[s];
            if (c == CMD_READ && len < d_len[s])
                r.msg_length = len;
            if (c != CMD_PEEK)
            begin
                free_u += d_units[s] + d_skip[s];
                if (free_u > total) free_u = total;
                rd_slot = (s + 1) % slots;
                held--;
            end
        end
        used = total - free_u;
        if (used == 0) r.used_percent = 0;
        else if (free_u == 0) r.used_percent = 100;
        else r.used_percent = 7'((longint'(used) * 100) / total);
        r.msg_count = 9'(held);
        return r;
    endfunction

    // result side: random stalls, checked against the oldest expectation
    always @(negedge clk)
        rsp.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);

    always @(posedge clk)
    begin
        rsp_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.status, rsp.payload_offset, rsp.msg_length,
                    rsp.used_percent, rsp.msg_count};
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.status != want.status || got.payload_offset != want.payload_offset ||
                    got.msg_length != want.msg_length ||
                    got.used_percent != want.used_percent ||
                    got.msg_count != want.msg_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic drain();
        wait (pending_rsp.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        // drop valid so the last command is not taken again once idle
        @(negedge clk);
        req.valid <= 1'b0;
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_UNIT_BYTES: reg_ub = data;
            REG_UNIT_COUNT: reg_uc = data & 16'h07FF;
            REG_SLOT_COUNT: reg_sc = data & 16'h01FF;
            default: return;
        endcase
        empty_ring();
    endtask

    // valid is only lowered when a gap is taken, so it never toggles in one step
    task automatic send_cmd(cmd_t c, logic [15:0] len, logic has_exp, rsp_t exp);
        rsp_t r;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.length <= len;
        do @(posedge clk); while (!req.ready);
        r = alloc_step(c, len);
        pending_rsp.push_back(has_exp ? exp : r);
    endtask

    function automatic logic [15:0] pick_len(cmd_t c);
        int unsigned ub;
        ub = eff_ub();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return (c == CMD_READ) ? 16'd0 : 16'(ub);
            2: return 16'(ub);
            default: return 16'($urandom_range(0, ub > 65535 ? 65535 : ub));
        endcase
    endfunction

    function automatic cmd_t pick_cmd();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 48) return CMD_WRITE;
        if (p < 70) return CMD_READ;
        if (p < 85) return CMD_PEEK;
        return CMD_SKIP;
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [15:0] data);
        row_t r;
        r = '{1'b1, idx, data, CMD_WRITE, 16'd0, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t cmd_row(cmd_t c, logic [15:0] len);
        row_t r;
        r = '{1'b0, REG_NONE, 16'd0, c, len, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t chk_row(cmd_t c, logic [15:0] len, status_t st,
                                     logic [25:0] off, logic [15:0] ml,
                                     logic [6:0] pct, logic [8:0] cnt);
        row_t r;
        r = '{1'b0, REG_NONE, 16'd0, c, len, 1'b1, '{st, off, ml, pct, cnt}};
        return r;
    endfunction

    initial
    begin
        rsp_t none;
        cmd_t c;
        logic [15:0] uc_pick [RAND_PHASES];
        logic [15:0] ub_pick [RAND_PHASES];
        logic [15:0] sc_pick [RAND_PHASES];

        none = '0;
        mismatches = 0;
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_UNIT_BYTES;
        cfg_data = '0;
        req.valid = 1'b0;
        req.cmd = CMD_WRITE;
        req.length = '0;
        rsp.ready = 1'b0;
        reg_ub = 256;
        reg_uc = 1024;
        reg_sc = 256;
        empty_ring();

        plan.push_back(chk_row(CMD_PEEK, 16'd0, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(chk_row(CMD_READ, 16'd0, ST_BAD_LEN, 0, 0, 0, 0));
        plan.push_back(chk_row(CMD_SKIP, 16'd0, ST_EMPTY, 0, 0, 0, 0));
        plan.push_back(chk_row(CMD_WRITE, 16'd257, ST_BAD_LEN, 0, 0, 0, 0));
        plan.push_back(chk_row(CMD_WRITE, 16'hFFFF, ST_BAD_LEN, 0, 0, 0, 0));
        plan.push_back(chk_row(CMD_WRITE, 16'd0, ST_OK, 4, 0, 0, 1));
        plan.push_back(chk_row(CMD_WRITE, 16'd256, ST_OK, 260, 256, 0, 2));
        plan.push_back(chk_row(CMD_PEEK, 16'd0, ST_OK, 4, 0, 0, 2));
        plan.push_back(chk_row(CMD_READ, 16'hFFFF, ST_OK, 4, 0, 0, 1));
        plan.push_back(chk_row(CMD_READ, 16'd1, ST_OK, 260, 1, 0, 0));
        // tiny ring: three units, two slots, four bytes per unit
        plan.push_back(cfg_row(REG_UNIT_COUNT, 16'd3));
        plan.push_back(cfg_row(REG_SLOT_COUNT, 16'd2));
        plan.push_back(cfg_row(REG_UNIT_BYTES, 16'd4));
        plan.push_back(chk_row(CMD_WRITE, 16'd4, ST_OK, 4, 4, 66, 1));
        plan.push_back(chk_row(CMD_WRITE, 16'd0, ST_OK, 12, 0, 100, 2));
        plan.push_back(chk_row(CMD_WRITE, 16'd0, ST_NO_SLOT, 0, 0, 100, 2));
        plan.push_back(chk_row(CMD_SKIP, 16'd0, ST_OK, 4, 4, 33, 1));
        plan.push_back(chk_row(CMD_WRITE, 16'd4, ST_OK, 4, 4, 100, 2));
        plan.push_back(chk_row(CMD_SKIP, 16'd0, ST_OK, 12, 0, 66, 1));
        // wrap would skip one tail unit, which leaves too little room
        plan.push_back(chk_row(CMD_WRITE, 16'd4, ST_NO_SPACE, 0, 0, 66, 1));
        plan.push_back(cmd_row(CMD_PEEK, 16'd0));
        plan.push_back(chk_row(CMD_WRITE, 16'd5, ST_BAD_LEN, 0, 0, 66, 1));
        // zero registers act as one
        plan.push_back(cfg_row(REG_UNIT_BYTES, 16'd0));
        plan.push_back(cfg_row(REG_UNIT_COUNT, 16'd0));
        plan.push_back(cfg_row(REG_SLOT_COUNT, 16'd0));
        plan.push_back(cmd_row(CMD_WRITE, 16'd0));
        plan.push_back(cmd_row(CMD_READ, 16'd3));
        // oversized registers clamp
        plan.push_back(cfg_row(REG_UNIT_COUNT, 16'd2047));
        plan.push_back(cfg_row(REG_SLOT_COUNT, 16'd511));
        plan.push_back(cfg_row(REG_UNIT_BYTES, 16'hFFFF));
        plan.push_back(chk_row(CMD_WRITE, 16'hFFFF, ST_OK, 4, 16'hFFFF, 0, 1));
        plan.push_back(cfg_row(REG_NONE, 16'hFFFF));
        plan.push_back(cmd_row(CMD_PEEK, 16'd0));
        plan.push_back(cmd_row(CMD_SKIP, 16'd0));

        ub_pick = '{16'd256, 16'd1, 16'd2, 16'd8, 16'hFFFF, 16'd3, 16'd16, 16'd100,
                    16'($urandom_range(0, 20)), 16'($urandom_range(0, 20))};
        uc_pick = '{16'd1024, 16'd40, 16'd7, 16'd16, 16'd5, 16'd1, 16'd1024, 16'd64,
                    16'($urandom_range(0, 60)), 16'($urandom_range(0, 60))};
        sc_pick = '{16'd256, 16'd8, 16'd3, 16'd4, 16'd256, 16'd1, 16'd256, 16'd64,
                    16'($urandom_range(0, 16)), 16'($urandom_range(0, 16))};

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_cmd(plan[i].cmd, plan[i].len, plan[i].has_exp, plan[i].exp);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            write_reg(REG_UNIT_BYTES, ub_pick[ph]);
            write_reg(REG_UNIT_COUNT, uc_pick[ph]);
            write_reg(REG_SLOT_COUNT, sc_pick[ph]);
            no_idle = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == PHASE_ITEMS / 2)
                begin
                    // hold off until all outstanding results are back
                    @(negedge clk);
                    req.valid <= 1'b0;
                    wait (pending_rsp.size() == 0);
                end
                c = pick_cmd();
                send_cmd(c, pick_len(c), 1'b0, none);
            end
        end
        no_idle = 1'b0;
        @(negedge clk);
        req.valid <= 1'b0;

        wait (pending_rsp.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
